// ===== rtl/stf_pkg.sv =====
// Shared widths, reset values and register indexes of the stereo flanger.
`default_nettype none

package stf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int DELAY_W        = 6;
  localparam int PHASE_W        = 24;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_IDX_W      = 1;
  localparam int COS_W          = 15;

  localparam int DELAY_DEPTH_DEF    = 64;
  localparam int COS_TABLE_BITS_DEF = 10;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RESET  = 6'd48;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 24'd350;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/stf_sweep.sv =====
// Sweep phase accumulator, quarter-wave cosine ROM and delay calculation.
`default_nettype none

module stf_sweep import stf_pkg::*; #(
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [PHASE_W-1:0] phase_step,
  input  wire logic [DELAY_W-1:0] max_delay,
  output logic      [DELAY_W-1:0] delay
);

  localparam int COS_N = 1 << COS_TABLE_BITS;
  localparam int AW    = COS_TABLE_BITS + 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182, 64'd240};

  typedef logic [COS_W-1:0] rom_t [COS_N+1];

  // Q30 Taylor series of the cosine, rounded to unsigned Q0.15 and clamped.
  function automatic rom_t cos_rom_build();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] mag;
    longint      sum;
    longint      v;
    for (int k = 0; k <= COS_N; k++) begin
      x   = (HALF_PI_Q30 * 64'(k)) / 64'(COS_N);
      x2  = (x * x) >> 30;
      mag = ONE_Q30;
      sum = longint'(ONE_Q30);
      for (int n = 0; n < 8; n++) begin
        mag = ((mag * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 0) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'(((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30);
      if (v > 32767) begin
        v = 32767;
      end
      if (k == COS_N) begin
        v = 0;
      end
      rom[k] = COS_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = cos_rom_build();

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [1:0]         quad;
  logic [COS_TABLE_BITS-1:0] idx;
  logic [AW-1:0]      rom_addr;
  logic [COS_W-1:0]   rom_q;
  logic               rom_neg;
  logic [15:0]        one_minus_cos;
  logic [21:0]        product;

  always_comb begin
    if (rst) begin
      phase_next = '0;
    end else if (advance) begin
      phase_next = phase + phase_step;
    end else begin
      phase_next = phase;
    end
  end

  assign quad     = phase_next[PHASE_W-1 -: 2];
  assign idx      = phase_next[PHASE_W-3 -: COS_TABLE_BITS];
  assign rom_addr = quad[0] ? (AW'(COS_N) - {1'b0, idx}) : {1'b0, idx};

  // The ROM output always matches the phase register.
  always_ff @(posedge clk) begin
    phase   <= phase_next;
    rom_q   <= COS_ROM[rom_addr];
    rom_neg <= quad[0] ^ quad[1];
  end

  assign one_minus_cos = rom_neg ? {1'b1, rom_q} : (16'h8000 - {1'b0, rom_q});
  assign product       = 22'(max_delay) * 22'(one_minus_cos);
  assign delay         = product[21:16];

endmodule

`default_nettype wire

// ===== rtl/stereo_flanger.sv =====
// Top level of the stereo flanger: configuration, delay ring and output stage.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  left_in, right_in
//   m_*       out        m_tvalid/m_tready  left_out, right_out, current_delay
//   cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One item is accepted per cycle unless a stalled output holds stage 1 full;
// each item is registered in stage 1, with the delay ring read, then in the output stage.
// Reset clears the write pointer and the ring fill count; ring entries not yet
// written since reset read as zero.
// A stalled output holds its result while one more item is taken in.
`default_nettype none

module stereo_flanger import stf_pkg::*; #(
  parameter int DELAY_DEPTH    = DELAY_DEPTH_DEF,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,   // left_in, right_in
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [39:0]           m_tdata,   // left_out, right_out, current_delay
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int CW   = $clog2(DELAY_DEPTH + 1);
  localparam int CMPW = (CW > DELAY_W) ? CW : DELAY_W;
  localparam logic [DELAY_W-1:0] DLY_CAP =
    (DELAY_DEPTH > 64) ? 6'd63 : DELAY_W'(DELAY_DEPTH - 1);

  logic [DELAY_W-1:0] max_delay;
  logic [PHASE_W-1:0] phase_step;

  logic [AW-1:0]      wp;
  logic [CW-1:0]      fill;
  logic               accept;
  logic [DELAY_W-1:0] delay_raw;
  logic [DELAY_W-1:0] delay;
  logic [AW:0]        wp_x;
  logic [AW:0]        delay_x;
  logic [AW:0]        rd_x;
  logic [AW-1:0]      rd_addr;

  logic signed [SAMPLE_W-1:0] ring_left  [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_right [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_left_q;
  logic signed [SAMPLE_W-1:0] ring_right_q;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_left;
  logic signed [SAMPLE_W-1:0] s1_right;
  logic [DELAY_W-1:0]         s1_delay;
  logic                       s1_bypass;
  logic                       s1_zero;

  logic                       out_take;
  logic signed [SAMPLE_W-1:0] tap_left;
  logic signed [SAMPLE_W-1:0] tap_right;
  logic signed [SAMPLE_W-1:0] sum_left;
  logic signed [SAMPLE_W-1:0] sum_right;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [DELAY_W-1:0]         current_delay;

  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] s;
    s = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      return s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return s[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay  <= MAX_DELAY_RESET;
      phase_step <= PHASE_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DELAY:  max_delay  <= cfg_data[DELAY_W-1:0];
        REG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_take = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || !m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  stf_sweep #(
    .COS_TABLE_BITS(COS_TABLE_BITS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .phase_step(phase_step),
    .max_delay (max_delay),
    .delay     (delay_raw)
  );

  assign delay   = (delay_raw > DLY_CAP) ? DLY_CAP : delay_raw;
  assign wp_x    = {1'b0, wp};
  assign delay_x = (AW+1)'(delay);
  assign rd_x    = (wp_x >= delay_x) ? (wp_x - delay_x)
                                     : (wp_x + (AW+1)'(DELAY_DEPTH) - delay_x);
  assign rd_addr = rd_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (accept) begin
      wp <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (fill != CW'(DELAY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_left[wp]  <= s_tdata[SAMPLE_W-1:0];
      ring_right[wp] <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      ring_left_q    <= ring_left[rd_addr];
      ring_right_q   <= ring_right[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left   <= s_tdata[SAMPLE_W-1:0];
      s1_right  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      s1_delay  <= delay;
      s1_bypass <= (delay == '0);
      s1_zero   <= (CMPW'(fill) < CMPW'(delay));
    end
  end

  // A zero delay returns the item itself; an entry older than the fill reads zero.
  always_comb begin
    if (s1_bypass) begin
      tap_left  = s1_left;
      tap_right = s1_right;
    end else if (s1_zero) begin
      tap_left  = '0;
      tap_right = '0;
    end else begin
      tap_left  = ring_left_q;
      tap_right = ring_right_q;
    end
  end

  assign sum_left  = sat_add(s1_left, tap_left);
  assign sum_right = sat_add(s1_right, tap_right);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      left_out      <= sum_left;
      right_out     <= sum_right;
      current_delay <= s1_delay;
    end
  end

  assign m_tdata = {2'b00, current_delay, right_out, left_out};

endmodule

`default_nettype wire

// ===== rtl/stf_checker.sv =====
// Port-level assertions for the stereo flanger and their bind to the top level.
`default_nettype none

module stf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output item changed.");

  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:32] <= 6'd62) && (m_tdata[39:38] == 2'b00))
    else $error("Delay field out of range or padding set.");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("Input stalled while output is free.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("Output item without matching input item.");

endmodule

bind stereo_flanger stf_checker u_stf_checker (.*);

`default_nettype wire
